### rtl/brl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// brl_pkg
// Shared widths, codes and beat types of the Bresenham line rasterizer.
// ---------------------------------------------------------------------------
package brl_pkg;

	localparam int COORD_BITS  = 12;
	localparam int ERR_BITS    = COORD_BITS + 2;
	localparam int CNT_BITS    = COORD_BITS + 1;
	localparam int COLOR_BITS  = 4;
	localparam int CFG_IDX_BITS = 2;

	localparam int CQ_DEPTH    = 4;
	localparam int CQ_AW       = 2;
	localparam int CQ_CNT_BITS = CQ_AW + 1;
	localparam int OQ_DEPTH    = 4;
	localparam int OQ_AW       = 2;
	localparam int OQ_CNT_BITS = OQ_AW + 1;

	localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

	typedef enum logic {
		KIND_START = 1'b0,
		KIND_STEP  = 1'b1
	} kind_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_CLIP_X_LOW  = 2'd0,
		CFG_CLIP_X_HIGH = 2'd1,
		CFG_CLIP_Y_LOW  = 2'd2,
		CFG_CLIP_Y_HIGH = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x_low;
		logic signed [COORD_BITS-1:0] x_high;
		logic signed [COORD_BITS-1:0] y_low;
		logic signed [COORD_BITS-1:0] y_high;
	} clip_t;

	// one decoded command between front and back
	typedef struct packed {
		kind_t                        kind;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic signed [ERR_BITS-1:0]   err;
		logic signed [ERR_BITS-1:0]   inc_axis;
		logic signed [ERR_BITS-1:0]   inc_diag;
		logic signed [1:0]            dir_x;
		logic signed [1:0]            dir_y;
		logic                         y_major;
		logic [CNT_BITS-1:0]          left;
		logic [COLOR_BITS-1:0]        color;
	} cmd_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [COLOR_BITS-1:0]        color;
		logic                         visible;
		logic                         last;
	} pix_t;

	function automatic logic signed [COORD_BITS-1:0] dir_ext(input logic signed [1:0] d);
		dir_ext = {{(COORD_BITS-2){d[1]}}, d};
	endfunction

endpackage
`default_nettype wire

### rtl/brl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// brl_front
// Takes input beats, works out the line setup and queues decoded commands.
// ---------------------------------------------------------------------------
module brl_front
	import brl_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic                         kind,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	input  wire logic [COLOR_BITS-1:0]        pen_color,
	output logic                              cmd_valid,
	output cmd_t                              cmd,
	input  wire logic                         cmd_pop
);

	logic                         valid_s1;
	kind_t                        kind_s1;
	logic signed [COORD_BITS-1:0] sx_s1;
	logic signed [COORD_BITS-1:0] sy_s1;
	logic signed [COORD_BITS:0]   dx_s1;
	logic signed [COORD_BITS:0]   dy_s1;
	logic [COLOR_BITS-1:0]        color_s1;

	cmd_t                         cq_mem_q [CQ_DEPTH];
	logic [CQ_AW-1:0]             cq_wr_q;
	logic [CQ_AW-1:0]             cq_rd_q;
	logic [CQ_CNT_BITS-1:0]       cq_cnt_q;

	logic                         cq_full;
	logic                         accept;
	logic                         move;

	logic signed [COORD_BITS:0]   adx_w;
	logic signed [COORD_BITS:0]   ady_w;
	logic [COORD_BITS-1:0]        adx;
	logic [COORD_BITS-1:0]        ady;
	logic [COORD_BITS-1:0]        major;
	logic [COORD_BITS-1:0]        minor;
	logic                         y_major;
	cmd_t                         setup;

	assign cq_full = (cq_cnt_q == CQ_CNT_BITS'(CQ_DEPTH));
	assign full    = valid_s1 && cq_full;
	assign accept  = push && !full;
	assign move    = valid_s1 && !cq_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	// deltas are one bit wider than the coordinates
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind_t'(kind);
			sx_s1    <= start_x;
			sy_s1    <= start_y;
			dx_s1    <= $signed({end_x[COORD_BITS-1], end_x})
			            - $signed({start_x[COORD_BITS-1], start_x});
			dy_s1    <= $signed({end_y[COORD_BITS-1], end_y})
			            - $signed({start_y[COORD_BITS-1], start_y});
			color_s1 <= pen_color;
		end
	end

	always_comb begin
		adx_w   = dx_s1[COORD_BITS] ? -dx_s1 : dx_s1;
		ady_w   = dy_s1[COORD_BITS] ? -dy_s1 : dy_s1;
		adx     = adx_w[COORD_BITS-1:0];
		ady     = ady_w[COORD_BITS-1:0];
		y_major = (ady > adx);
		major   = y_major ? ady : adx;
		minor   = y_major ? adx : ady;

		setup.kind     = kind_s1;
		setup.x        = sx_s1;
		setup.y        = sy_s1;
		setup.err      = $signed({1'b0, minor, 1'b0}) - $signed({2'b00, major});
		setup.inc_axis = $signed({1'b0, minor, 1'b0});
		setup.inc_diag = $signed({1'b0, minor, 1'b0}) - $signed({1'b0, major, 1'b0});
		setup.dir_x    = dx_s1[COORD_BITS] ? 2'sb11 : ((dx_s1 != '0) ? 2'sb01 : 2'sb00);
		setup.dir_y    = dy_s1[COORD_BITS] ? 2'sb11 : ((dy_s1 != '0) ? 2'sb01 : 2'sb00);
		setup.y_major  = y_major;
		setup.left     = CNT_BITS'({1'b0, major}) + CNT_BITS'(1);
		setup.color    = color_s1;
	end

	always_ff @(posedge clk) begin
		if (move) begin
			cq_mem_q[cq_wr_q] <= setup;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cq_wr_q  <= '0;
			cq_rd_q  <= '0;
			cq_cnt_q <= '0;
		end else begin
			if (move) begin
				cq_wr_q <= cq_wr_q + CQ_AW'(1);
			end
			if (cmd_pop) begin
				cq_rd_q <= cq_rd_q + CQ_AW'(1);
			end
			case ({move, cmd_pop})
				2'b10:   cq_cnt_q <= cq_cnt_q + CQ_CNT_BITS'(1);
				2'b01:   cq_cnt_q <= cq_cnt_q - CQ_CNT_BITS'(1);
				default: cq_cnt_q <= cq_cnt_q;
			endcase
		end
	end

	assign cmd_valid = (cq_cnt_q != '0);
	assign cmd       = cq_mem_q[cq_rd_q];

endmodule
`default_nettype wire

### rtl/brl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// brl_back
// Holds the active line, steps it one pixel per step command and queues pixels.
// ---------------------------------------------------------------------------
module brl_back
	import brl_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cmd_valid,
	input  wire cmd_t                   cmd,
	output logic                        cmd_pop,
	input  wire clip_t                  clip,
	output logic                        empty,
	input  wire logic                   pop,
	output pix_t                        pix
);

	logic signed [COORD_BITS-1:0] cur_x_q;
	logic signed [COORD_BITS-1:0] cur_y_q;
	logic signed [ERR_BITS-1:0]   err_q;
	logic signed [ERR_BITS-1:0]   inc_axis_q;
	logic signed [ERR_BITS-1:0]   inc_diag_q;
	logic signed [1:0]            dir_x_q;
	logic signed [1:0]            dir_y_q;
	logic                         y_major_q;
	logic [CNT_BITS-1:0]          left_q;
	logic [COLOR_BITS-1:0]        color_q;
	logic                         active_q;

	pix_t                         oq_mem_q [OQ_DEPTH];
	logic [OQ_AW-1:0]             oq_wr_q;
	logic [OQ_AW-1:0]             oq_rd_q;
	logic [OQ_CNT_BITS-1:0]       oq_cnt_q;

	logic                         oq_full;
	logic                         load;
	logic                         emit;
	logic                         out_pop;
	logic                         err_ge0;
	logic                         step_x;
	logic                         step_y;
	pix_t                         pix_new;

	assign oq_full = (oq_cnt_q == OQ_CNT_BITS'(OQ_DEPTH));
	assign load    = cmd_valid && (cmd.kind == KIND_START);
	assign emit    = cmd_valid && (cmd.kind == KIND_STEP) && active_q && !oq_full;
	// a step with no active line is dropped without waiting on the output side
	assign cmd_pop = load || emit || (cmd_valid && (cmd.kind == KIND_STEP) && !active_q);
	assign out_pop = pop && !empty;

	assign err_ge0 = !err_q[ERR_BITS-1];
	assign step_x  = !y_major_q || err_ge0;
	assign step_y  = y_major_q || err_ge0;

	always_comb begin
		pix_new.x       = cur_x_q;
		pix_new.y       = cur_y_q;
		pix_new.color   = color_q;
		pix_new.visible = (cur_x_q > clip.x_low) && (cur_x_q < clip.x_high)
		                  && (cur_y_q > clip.y_low) && (cur_y_q < clip.y_high);
		pix_new.last    = (left_q == CNT_BITS'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q    <= '0;
			cur_y_q    <= '0;
			err_q      <= '0;
			inc_axis_q <= '0;
			inc_diag_q <= '0;
			dir_x_q    <= '0;
			dir_y_q    <= '0;
			y_major_q  <= 1'b0;
			left_q     <= '0;
			color_q    <= '0;
			active_q   <= 1'b0;
		end else if (load) begin
			cur_x_q    <= cmd.x;
			cur_y_q    <= cmd.y;
			err_q      <= cmd.err;
			inc_axis_q <= cmd.inc_axis;
			inc_diag_q <= cmd.inc_diag;
			dir_x_q    <= cmd.dir_x;
			dir_y_q    <= cmd.dir_y;
			y_major_q  <= cmd.y_major;
			left_q     <= cmd.left;
			color_q    <= cmd.color;
			active_q   <= 1'b1;
		end else if (emit) begin
			cur_x_q  <= cur_x_q + (step_x ? dir_ext(dir_x_q) : '0);
			cur_y_q  <= cur_y_q + (step_y ? dir_ext(dir_y_q) : '0);
			err_q    <= err_q + (err_ge0 ? inc_diag_q : inc_axis_q);
			left_q   <= left_q - CNT_BITS'(1);
			active_q <= (left_q != CNT_BITS'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			oq_mem_q[oq_wr_q] <= pix_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (emit) begin
				oq_wr_q <= oq_wr_q + OQ_AW'(1);
			end
			if (out_pop) begin
				oq_rd_q <= oq_rd_q + OQ_AW'(1);
			end
			case ({emit, out_pop})
				2'b10:   oq_cnt_q <= oq_cnt_q + OQ_CNT_BITS'(1);
				2'b01:   oq_cnt_q <= oq_cnt_q - OQ_CNT_BITS'(1);
				default: oq_cnt_q <= oq_cnt_q;
			endcase
		end
	end

	assign empty = (oq_cnt_q == '0);
	assign pix   = oq_mem_q[oq_rd_q];

endmodule
`default_nettype wire

### rtl/bresenham_line_rasterizer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bresenham_line_rasterizer
// Line rasterizer: start beats set up a line, step beats on an active line give one pixel each.
// ---------------------------------------------------------------------------
// Path: a step beat goes through the input register, command and pixel queues.
// Throughput: one beat per cycle in, one pixel per cycle out, while full is low
//   and the pixel queue has room, set by the error-term update in the back end.
// Reset: arst_n clears all queues and the line state; no line is active and
//   the clip bounds reset to the extremes, which the strict window excludes.
module bresenham_line_rasterizer
	import brl_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic                         kind,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	input  wire logic [COLOR_BITS-1:0]        pen_color,
	output logic                              empty,
	input  wire logic                         pop,
	output logic signed [COORD_BITS-1:0]      pixel_x,
	output logic signed [COORD_BITS-1:0]      pixel_y,
	output logic [COLOR_BITS-1:0]             pixel_color,
	output logic                              visible,
	output logic                              last,
	input  wire logic                         cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
	input  wire logic [COORD_BITS-1:0]        cfg_data
);

	clip_t clip_q;
	logic  cmd_valid;
	cmd_t  cmd;
	logic  cmd_pop;
	pix_t  pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q.x_low  <= COORD_MIN;
			clip_q.x_high <= COORD_MAX;
			clip_q.y_low  <= COORD_MIN;
			clip_q.y_high <= COORD_MAX;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_CLIP_X_LOW:  clip_q.x_low  <= $signed(cfg_data);
				CFG_CLIP_X_HIGH: clip_q.x_high <= $signed(cfg_data);
				CFG_CLIP_Y_LOW:  clip_q.y_low  <= $signed(cfg_data);
				CFG_CLIP_Y_HIGH: clip_q.y_high <= $signed(cfg_data);
			endcase
		end
	end

	brl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.pen_color (pen_color),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	brl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.clip      (clip_q),
		.empty     (empty),
		.pop       (pop),
		.pix       (pix)
	);

	assign pixel_x     = pix.x;
	assign pixel_y     = pix.y;
	assign pixel_color = pix.color;
	assign visible     = pix.visible;
	assign last        = pix.last;

endmodule
`default_nettype wire

### rtl/brl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// brl_checker
// Port-level checks of the line rasterizer, bound to the top level.
// ---------------------------------------------------------------------------
module brl_checker
	import brl_pkg::*;
(
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         push,
	input wire logic                         full,
	input wire logic                         empty,
	input wire logic                         pop,
	input wire logic signed [COORD_BITS-1:0] pixel_x,
	input wire logic signed [COORD_BITS-1:0] pixel_y,
	input wire logic [COLOR_BITS-1:0]        pixel_color,
	input wire logic                         visible,
	input wire logic                         last
);

	// a waiting result beat is not withdrawn
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result beat withdrawn while stalled");

	// a stalled result beat keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(pixel_x) && $stable(pixel_y)
		&& $stable(pixel_color) && $stable(visible) && $stable(last)))
		else $error("result payload changed while stalled");

	// strict window: a visible pixel never sits on the coordinate extremes
	assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && visible) |-> (pixel_x != COORD_MIN && pixel_x != COORD_MAX
		&& pixel_y != COORD_MIN && pixel_y != COORD_MAX))
		else $error("visible pixel on the window edge");

	// back-pressure only builds from a beat taken the cycle before
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full raised without an input beat");

endmodule

bind bresenham_line_rasterizer brl_checker u_brl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.push        (push),
	.full        (full),
	.empty       (empty),
	.pop         (pop),
	.pixel_x     (pixel_x),
	.pixel_y     (pixel_y),
	.pixel_color (pixel_color),
	.visible     (visible),
	.last        (last)
);
`default_nettype wire
